>>> rtl/ifl_pkg.sv
// Shared types, sizes and the range merge function for the interval free list.
// No dependencies; used by every module in rtl/.
package ifl_pkg;

  localparam int TableEntries = 64;
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int AddrW        = 32;
  localparam int AlignW       = 17;
  localparam int SecW         = 8;
  localparam int IdxW         = 6;

  typedef struct packed {
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  limit;
    logic [AlignW-1:0] align;
    logic [SecW-1:0]   section;
  } entry_t;

  typedef enum logic [1:0] {
    StMerged   = 2'd0,
    StInserted = 2'd1,
    StDropped  = 2'd2,
    StRead     = 2'd3
  } status_t;

  typedef enum logic {
    ReqMark = 1'b0,
    ReqRead = 1'b1
  } req_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic [CntW-1:0] wp;
  } qctl_t;

  typedef struct packed {
    logic take_next;
    logic take_din;
  } cell_ctl_t;

  typedef struct packed {
    logic   ok;
    entry_t ent;
  } merge_t;

  // e is the table or held entry, t the range being folded into it
  function automatic merge_t try_merge(entry_t e, entry_t t, logic keyed);
    entry_t           lo;
    entry_t           hi;
    entry_t           win;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] reach;
    merge_t           r;
    if (e.base >= t.base) begin
      lo = t;
      hi = e;
    end else begin
      lo = e;
      hi = t;
    end
    mask  = (hi.align == '0) ? '0 : {{(AddrW-AlignW){1'b0}}, hi.align - AlignW'(1)};
    reach = keyed ? ((lo.limit + mask) & ~mask) : lo.limit;
    win   = (lo.limit > hi.limit) ? lo : hi;
    r.ok  = (!keyed || (e.section == t.section)) && !(reach < hi.base);
    r.ent.base    = lo.base;
    r.ent.limit   = win.limit;
    r.ent.align   = keyed ? win.align : e.align;
    r.ent.section = e.section;
    return r;
  endfunction

endpackage

>>> rtl/interval_free_list_coalesce.sv
// Top level: stream ports, APB register, chain of table cells and the sequencer.
// Depends on ifl_pkg, ifl_cell, ifl_engine.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tuser req_type, tdata range fields
//   m_axis   out  m_axis_tvalid/tready      tuser status, tdata count + entry
//   apb      in   psel/penable/pwrite       keyed_mode at 0x0
//
// A request with n stored entries (up to 64) streams the table once through the
// head cell of the chain, one entry a cycle outside the merge-decision states.
// Reset empties the table and sets keyed mode; no clearing pass.
// A pending result waits in the output register; the next request is taken
// once the previous one has reached that register.
module interval_free_list_coalesce (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start[31:0], end[63:32], align[80:64], section[88:81], read_index[94:89]
  input  logic [95:0] s_axis_tdata,
  // req_type
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_count[6:0], start[38:7], end[70:39], align[87:71], section[95:88]
  output logic [95:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ifl_pkg::*;

  localparam logic RegKeyed = 1'b0;

  logic            keyed;
  entry_t          s_entry;
  entry_t          m_entry;
  status_t         m_status;
  logic [CntW-1:0] m_count;
  qctl_t           qctl;
  entry_t          din;
  entry_t          cq [TableEntries];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegKeyed) ? {31'b0, keyed} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyed <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == RegKeyed) begin
      keyed <= pwdata[0];
    end
  end

  assign s_entry.base    = s_axis_tdata[31:0];
  assign s_entry.limit   = s_axis_tdata[63:32];
  assign s_entry.align   = s_axis_tdata[80:64];
  assign s_entry.section = s_axis_tdata[88:81];

  assign m_axis_tdata = {m_entry.section, m_entry.align, m_entry.limit, m_entry.base,
                         7'(m_count)};
  assign m_axis_tuser = m_status;

  ifl_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .keyed    (keyed),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_req    (req_t'(s_axis_tuser[0])),
    .s_entry  (s_entry),
    .s_idx    (s_axis_tdata[94:89]),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_status (m_status),
    .m_count  (m_count),
    .m_entry  (m_entry),
    .head     (cq[0]),
    .qctl     (qctl),
    .din      (din)
  );

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    cell_ctl_t cctl;
    entry_t    nxt;
    assign cctl.take_next = qctl.pop && (CntW'(i) < qctl.wp);
    assign cctl.take_din  = qctl.push && (CntW'(i) == qctl.wp);
    if (i < TableEntries - 1) begin : g_mid
      assign nxt = cq[i+1];
    end else begin : g_last
      assign nxt = din;
    end
    ifl_cell u_cell (
      .clk  (clk),
      .cctl (cctl),
      .nxt  (nxt),
      .din  (din),
      .q    (cq[i])
    );
  end

endmodule

>>> rtl/ifl_cell.sv
// One table slot of the shifting entry chain.
// Depends on ifl_pkg.
module ifl_cell (
  input  logic               clk,
  input  ifl_pkg::cell_ctl_t cctl,
  input  ifl_pkg::entry_t    nxt,
  input  ifl_pkg::entry_t    din,
  output ifl_pkg::entry_t    q
);
  import ifl_pkg::*;

  always_ff @(posedge clk) begin
    if (cctl.take_next) begin
      q <= nxt;
    end else if (cctl.take_din) begin
      q <= din;
    end
  end

endmodule

>>> rtl/ifl_engine.sv
// Request sequencer: streams the table through the chain head once per request,
// searching, merging, absorbing and inserting, or reading one entry by index.
// Holds the result register. Depends on ifl_pkg.
module ifl_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  keyed,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  ifl_pkg::req_t         s_req,
  input  ifl_pkg::entry_t       s_entry,
  input  logic [ifl_pkg::IdxW-1:0] s_idx,
  output logic                  m_valid,
  input  logic                  m_ready,
  output ifl_pkg::status_t      m_status,
  output logic [ifl_pkg::CntW-1:0] m_count,
  output ifl_pkg::entry_t       m_entry,
  input  ifl_pkg::entry_t       head,
  output ifl_pkg::qctl_t        qctl,
  output ifl_pkg::entry_t       din
);
  import ifl_pkg::*;

  typedef enum logic [3:0] {
    IDLE, READ, SEARCH, TRY_PREV, TRY_CUR, END_INSERT, ABSORB, COPY, FINISH
  } state_t;

  state_t          state;
  entry_t          t;
  entry_t          hold;
  logic            hold_v;
  entry_t          rd;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] left;
  logic [CntW-1:0] k;
  logic [CntW-1:0] qcnt;
  status_t         st;

  entry_t ma;
  entry_t mb;
  merge_t mres;
  logic   flag;
  logic   full;
  logic   pop;
  logic   push;

  assign s_ready = (state == IDLE);
  assign full    = (qcnt == CntW'(TableEntries));
  assign flag    = (keyed && (head.section < t.section)) || (head.base < t.base);

  always_comb begin
    case (state)
      TRY_CUR: begin
        ma = head;
        mb = t;
      end
      ABSORB: begin
        ma = hold;
        mb = head;
      end
      default: begin
        ma = hold;
        mb = t;
      end
    endcase
    mres = try_merge(ma, mb, keyed);
  end

  always_comb begin
    pop  = 1'b0;
    push = 1'b0;
    din  = hold;
    case (state)
      READ: begin
        if (left != '0) begin
          pop  = 1'b1;
          push = 1'b1;
          din  = head;
        end
      end
      SEARCH: begin
        if (left != '0 && flag) begin
          pop  = 1'b1;
          push = hold_v;
        end
      end
      TRY_PREV: begin
        push = !mres.ok;
      end
      TRY_CUR: begin
        if (mres.ok) begin
          pop = 1'b1;
        end else if (!full) begin
          push = 1'b1;
          din  = t;
        end
      end
      END_INSERT: begin
        push = !full;
        din  = t;
      end
      ABSORB: begin
        if (left == '0) begin
          push = 1'b1;
        end else begin
          pop = mres.ok;
        end
      end
      COPY: begin
        pop  = (left != '0);
        push = hold_v;
      end
      default: begin
        pop  = 1'b0;
      end
    endcase
    qctl.pop  = pop;
    qctl.push = push;
    qctl.wp   = pop ? qcnt - CntW'(1) : qcnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      qcnt    <= '0;
      hold_v  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      qcnt <= qcnt - CntW'(pop) + CntW'(push);
      if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_valid) begin
            t      <= s_entry;
            idx    <= s_idx;
            left   <= qcnt;
            k      <= '0;
            hold_v <= 1'b0;
            rd     <= '0;
            state  <= (s_req == ReqRead) ? READ : SEARCH;
          end
        end
        READ: begin
          if (left == '0) begin
            st    <= StRead;
            state <= FINISH;
          end else begin
            if (k == CntW'(idx)) begin
              rd <= head;
            end
            k    <= k + CntW'(1);
            left <= left - CntW'(1);
          end
        end
        SEARCH: begin
          if (left == '0) begin
            state <= hold_v ? TRY_PREV : END_INSERT;
          end else if (flag) begin
            hold   <= head;
            hold_v <= 1'b1;
            left   <= left - CntW'(1);
          end else begin
            state <= hold_v ? TRY_PREV : TRY_CUR;
          end
        end
        TRY_PREV: begin
          if (mres.ok) begin
            hold  <= mres.ent;
            st    <= StMerged;
            state <= ABSORB;
          end else begin
            hold_v <= 1'b0;
            state  <= (left != '0) ? TRY_CUR : END_INSERT;
          end
        end
        TRY_CUR: begin
          if (mres.ok) begin
            hold   <= mres.ent;
            hold_v <= 1'b1;
            left   <= left - CntW'(1);
            st     <= StMerged;
            state  <= ABSORB;
          end else begin
            st    <= full ? StDropped : StInserted;
            state <= COPY;
          end
        end
        END_INSERT: begin
          st    <= full ? StDropped : StInserted;
          state <= FINISH;
        end
        ABSORB: begin
          if (left == '0) begin
            hold_v <= 1'b0;
            state  <= FINISH;
          end else if (mres.ok) begin
            hold <= mres.ent;
            left <= left - CntW'(1);
          end else begin
            state <= COPY;
          end
        end
        COPY: begin
          if (left == '0) begin
            hold_v <= 1'b0;
            state  <= FINISH;
          end else begin
            hold   <= head;
            hold_v <= 1'b1;
            left   <= left - CntW'(1);
          end
        end
        FINISH: begin
          if (!m_valid || m_ready) begin
            m_valid  <= 1'b1;
            m_status <= st;
            m_count  <= qcnt;
            m_entry  <= (st == StRead) ? rd : '0;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= CntW'(TableEntries)) else $error("entry count above capacity");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qcnt != '0) else $error("pop from empty chain");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !full) else $error("push into full chain");
  a_idle_balanced: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !hold_v) else $error("held entry lost at request end");
`endif

endmodule
